// File: rtl/core/rv32im_integer_alu_macros.svh
// assertion macros for the rv32im integer alu
// no dependencies; included by the top level
`ifndef RV32IM_INTEGER_ALU_MACROS_SVH
`define RV32IM_INTEGER_ALU_MACROS_SVH
`ifndef SYNTH
`define RIA_ASSERT_IMPL(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("assertion failed");
`define RIA_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("assertion failed");
`else
`define RIA_ASSERT_IMPL(label, clk, rst_n, cond, conseq)
`define RIA_ASSERT_NEXT(label, clk, rst_n, cond, conseq)
`endif
`endif

// File: rtl/core/ria_pkg.sv
// shared types and codes for the rv32im integer alu
// no dependencies
`default_nettype none
package ria_pkg;
    localparam int unsigned XLEN = 32;
    localparam int unsigned QDEPTH = 2;
    localparam logic [4:0] SHAMT_MASK = 5'h1f;

    typedef enum logic [1:0] {
        CLS_LOGIC = 2'd0,
        CLS_MUL   = 2'd1,
        CLS_DIV   = 2'd2
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic [2:0]  funct3;
        logic        sub_sel;
        logic        sra_sel;
        logic [31:0] a;
        logic [31:0] b;
    } op_t;
endpackage
`default_nettype wire

// File: rtl/core/ria_front.sv
// front end: accepts items, classifies them, queues them for the back end
// depends on ria_pkg
`default_nettype none
module ria_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [2:0]    funct3,
    input  wire logic          alt_bit,
    input  wire logic          muldiv_bit,
    input  wire logic          register_form,
    input  wire logic [31:0]   operand_a,
    input  wire logic [31:0]   operand_b,
    output logic               q_valid,
    output ria_pkg::op_t       q_op,
    input  wire logic          q_pop
);
    ria_pkg::op_t op_in;
    ria_pkg::op_t mem_reg [ria_pkg::QDEPTH];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   cnt_reg, cnt_next;
    logic         push;

    always_comb
    begin
        op_in.funct3  = funct3;
        op_in.a       = operand_a;
        op_in.b       = operand_b;
        op_in.sub_sel = register_form & alt_bit;
        op_in.sra_sel = alt_bit;
        if (register_form && muldiv_bit)
            op_in.cls = funct3[2] ? ria_pkg::CLS_DIV : ria_pkg::CLS_MUL;
        else
            op_in.cls = ria_pkg::CLS_LOGIC;
    end

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start & ~busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_op    = mem_reg[rd_ptr_reg];
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= op_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/ria_div.sv
// radix-2 restoring divider, one quotient bit per cycle, m-extension fixups
// depends on ria_pkg
`default_nettype none
module ria_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic [2:0]  funct3,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic             idle,
    output logic             done,
    output logic [31:0]      quo
);
    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIX} state_t;
    state_t      state_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg, q_reg, d_reg;
    logic        neg_q_reg, neg_r_reg, want_rem_reg, zero_reg;
    logic [31:0] a_in_reg;
    logic        done_reg;
    logic [31:0] quo_reg;
    logic        sgn, na, nb;
    logic [32:0] trial;
    logic [31:0] rem_sh;
    logic [31:0] q_fix, r_fix;

    assign sgn    = ~funct3[0];
    assign na     = sgn & a[31];
    assign nb     = sgn & b[31];
    assign rem_sh = {rem_reg[30:0], q_reg[31]};
    assign trial  = {rem_reg[31], rem_sh} - {1'b0, d_reg};
    assign q_fix  = neg_q_reg ? (32'd0 - q_reg) : q_reg;
    assign r_fix  = neg_r_reg ? (32'd0 - rem_reg) : rem_reg;
    assign idle   = (state_reg == ST_IDLE);
    assign done   = done_reg;
    assign quo    = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (go)
                    begin
                        state_reg <= ST_RUN;
                        cnt_reg   <= 5'd0;
                        rem_reg   <= 32'd0;
                        q_reg     <= na ? (32'd0 - a) : a;
                        d_reg     <= nb ? (32'd0 - b) : b;
                        neg_q_reg <= na ^ nb;
                        neg_r_reg <= na;
                        want_rem_reg <= funct3[1];
                        zero_reg  <= (b == 32'd0);
                        a_in_reg  <= a;
                    end
                end
                ST_RUN:
                begin
                    // shift one dividend bit in, subtract if it fits
                    if (!trial[32])
                        rem_reg <= trial[31:0];
                    else
                        rem_reg <= rem_sh;
                    q_reg   <= {q_reg[30:0], ~trial[32]};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                        state_reg <= ST_FIX;
                end
                ST_FIX:
                begin
                    // magnitudes handle overflow naturally; zero divisor handled here
                    if (zero_reg)
                        quo_reg <= want_rem_reg ? a_in_reg : 32'hffff_ffff;
                    else
                        quo_reg <= want_rem_reg ? r_fix : q_fix;
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/ria_back.sv
// back end: registered alu, two-stage multiplier, iterative divider
// depends on ria_pkg, ria_div
`default_nettype none
module ria_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  ria_pkg::op_t       q_op,
    output logic               q_pop,
    output logic               done,
    output logic [31:0]        result
);
    logic        div_idle, div_done, div_go;
    logic [31:0] div_quo;
    logic        mul_busy;
    logic [4:0]  sh;
    logic [31:0] alu_res;
    logic [32:0] mx, my;
    logic        mul_v_reg, mul_hi_reg;
    logic [65:0] prod_reg;
    logic        alu_v_reg;
    logic [31:0] alu_res_reg;
    logic        done_reg;
    logic [31:0] result_reg;

    assign sh = q_op.b[4:0] & ria_pkg::SHAMT_MASK;

    always_comb
    begin
        case (q_op.funct3)
            3'd0: alu_res = q_op.sub_sel ? q_op.a - q_op.b : q_op.a + q_op.b;
            3'd1: alu_res = q_op.a << sh;
            3'd2: alu_res = {31'd0, $signed(q_op.a) < $signed(q_op.b)};
            3'd3: alu_res = {31'd0, q_op.a < q_op.b};
            3'd4: alu_res = q_op.a ^ q_op.b;
            3'd5: alu_res = q_op.sra_sel ? 32'($signed(q_op.a) >>> sh) : q_op.a >> sh;
            3'd6: alu_res = q_op.a | q_op.b;
            default: alu_res = q_op.a & q_op.b;
        endcase
        mx = {(q_op.funct3 != 3'd3) & q_op.a[31], q_op.a};
        my = {(q_op.funct3[1] == 1'b0) & q_op.b[31], q_op.b};
    end

    // the divider takes its item from the queue as it starts; later items wait at the queue head until it is idle
    assign mul_busy = 1'b0;
    assign div_go   = q_valid & (q_op.cls == ria_pkg::CLS_DIV) & div_idle;
    always_comb
    begin
        q_pop = 1'b0;
        if (q_valid)
        begin
            if (q_op.cls == ria_pkg::CLS_DIV)
                q_pop = div_idle & ~mul_busy;
            else
                q_pop = div_idle;
        end
    end

    ria_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (div_go),
        .funct3 (q_op.funct3),
        .a      (q_op.a),
        .b      (q_op.b),
        .idle   (div_idle),
        .done   (div_done),
        .quo    (div_quo)
    );

    always_ff @(posedge clk)
    begin
        prod_reg    <= 66'($signed(mx) * $signed(my));
        mul_hi_reg  <= (q_op.funct3 != 3'd0);
        alu_res_reg <= alu_res;
        result_reg  <= div_done ? div_quo
                     : mul_v_reg ? (mul_hi_reg ? prod_reg[63:32] : prod_reg[31:0])
                     : alu_res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_v_reg <= 1'b0;
            alu_v_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            mul_v_reg <= q_pop & (q_op.cls == ria_pkg::CLS_MUL);
            alu_v_reg <= q_pop & (q_op.cls == ria_pkg::CLS_LOGIC);
            done_reg  <= div_done | mul_v_reg | alu_v_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
endmodule
`default_nettype wire

// File: rtl/core/rv32im_integer_alu.sv
// rv32im integer alu top level: front queue plus execution back end
// depends on ria_pkg, ria_front, ria_back, rv32im_integer_alu_macros.svh
//
// channel   handshake        payload
// item in   start / busy     funct3 alt_bit muldiv_bit register_form operand_a operand_b
// result    done (strobe)    result
//
// alu and multiply items: one per cycle while the divider is idle; results pass through
// alu_res_reg or prod_reg, then result_reg; the bit-serial divider blocks the queue head
// results leave in item order; busy rises when the two-entry queue is full
// reset clears queue, pipeline valids and divider state; the receiver cannot stall
`default_nettype none
`include "rv32im_integer_alu_macros.svh"
module rv32im_integer_alu (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  funct3,
    input  wire logic        alt_bit,
    input  wire logic        muldiv_bit,
    input  wire logic        register_form,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    output logic             done,
    output logic [31:0]      result
);
    logic         q_valid, q_pop;
    ria_pkg::op_t q_op;

    ria_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .funct3        (funct3),
        .alt_bit       (alt_bit),
        .muldiv_bit    (muldiv_bit),
        .register_form (register_form),
        .operand_a     (operand_a),
        .operand_b     (operand_b),
        .q_valid       (q_valid),
        .q_op          (q_op),
        .q_pop         (q_pop)
    );

    ria_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_pop   (q_pop),
        .done    (done),
        .result  (result)
    );

    `RIA_ASSERT_IMPL(a_pop_needs_valid, clk, rst_n, q_pop, q_valid)
    `RIA_ASSERT_NEXT(a_accept_fills, clk, rst_n, start && !busy && !q_pop, q_valid)
endmodule
`default_nettype wire

// File: dv/tb_top.sv
// testbench for the rv32im integer alu: random and directed operations
// checked against a predictor of the alu and m extension; needs only the rtl
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_MUL    = 3'd0;
    localparam logic [2:0] F3_MULH   = 3'd1;
    localparam logic [2:0] F3_MULHSU = 3'd2;
    localparam logic [2:0] F3_MULHU  = 3'd3;
    localparam logic [2:0] F3_DIV    = 3'd4;
    localparam logic [2:0] F3_DIVU   = 3'd5;
    localparam logic [2:0] F3_REM    = 3'd6;
    localparam logic [2:0] F3_REMU   = 3'd7;
    localparam int unsigned N_RANDOM = 1250;

    class alu_scoreboard;
        logic [31:0] pending_results[$];
        int unsigned mismatches;

        function logic [31:0] muldiv_value(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
            logic [63:0] x;
            logic [63:0] y;
            logic [63:0] p;
            logic [31:0] ma;
            logic [31:0] mb;
            logic [31:0] q;
            logic [31:0] r;
            x = {{32{a[31]}}, a};
            y = {{32{b[31]}}, b};
            case (f3)
                F3_MUL:    return a * b;
                F3_MULH:   begin p = x * y; return p[63:32]; end
                F3_MULHSU: begin p = x * {32'd0, b}; return p[63:32]; end
                F3_MULHU:  begin p = {32'd0, a} * {32'd0, b}; return p[63:32]; end
                F3_DIVU:   return (b == 0) ? 32'hffffffff : a / b;
                F3_REMU:   return (b == 0) ? a : a % b;
                default:
                begin
                    if (b == 0)
                        return (f3 == F3_DIV) ? 32'hffffffff : a;
                    if (a == 32'h80000000 && b == 32'hffffffff)
                        return (f3 == F3_DIV) ? 32'h80000000 : 32'd0;
                    ma = a[31] ? -a : a;
                    mb = b[31] ? -b : b;
                    q = ma / mb;
                    r = ma % mb;
                    if (f3 == F3_DIV)
                        return (a[31] != b[31]) ? -q : q;
                    return a[31] ? -r : r;
                end
            endcase
        endfunction

        function logic [31:0] alu_value(logic [2:0] f3, logic alt, logic md, logic rf,
                                        logic [31:0] a, logic [31:0] b);
            logic [4:0] sh;
            sh = b[4:0];
            if (rf && md)
                return muldiv_value(f3, a, b);
            case (f3)
                F3_ADD:  return (rf && alt) ? a - b : a + b;
                F3_SLL:  return a << sh;
                F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
                F3_XOR:  return a ^ b;
                F3_SRL:  return alt ? 32'($signed(a) >>> sh) : a >> sh;
                F3_OR:   return a | b;
                default: return a & b;
            endcase
        endfunction

        function void note_item(logic [2:0] f3, logic alt, logic md, logic rf,
                                logic [31:0] a, logic [31:0] b);
            pending_results.push_back(alu_value(f3, alt, md, rf, a, b));
        endfunction

        function void check_result(logic [31:0] got);
            logic [31:0] want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] funct3 = '0;
    logic alt_bit = 1'b0;
    logic muldiv_bit = 1'b0;
    logic register_form = 1'b0;
    logic [31:0] operand_a = '0;
    logic [31:0] operand_b = '0;
    logic done;
    logic [31:0] result;

    alu_scoreboard sb = new();

    always #10 clk = ~clk;

    rv32im_integer_alu dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .funct3(funct3), .alt_bit(alt_bit), .muldiv_bit(muldiv_bit),
        .register_form(register_form), .operand_a(operand_a), .operand_b(operand_b),
        .done(done), .result(result)
    );

    // acceptance and results sampled on the edge, before the drivers' updates land
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_item(funct3, alt_bit, muldiv_bit, register_form, operand_a, operand_b);
        if (rst_n && done)
            sb.check_result(result);
    end

    function logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hffffffff;
            2: return 32'h80000000;
            3: return 32'h7fffffff;
            4: return $urandom_range(0, 40);
            5: return -$urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(logic [2:0] f3, logic alt, logic md, logic rf,
                             logic [31:0] a, logic [31:0] b, int unsigned gap);
        funct3 <= f3;
        alt_bit <= alt;
        muldiv_bit <= md;
        register_form <= rf;
        operand_a <= a;
        operand_b <= b;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    initial
    begin
        int unsigned k;
        int unsigned wait_cycles;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: every m-extension operation, divide by zero, signed overflow, shift extremes
        for (k = 0; k < 8; k++)
        begin
            send_item(k[2:0], 1'b1, 1'b1, 1'b1, 32'h80000000, 32'hffffffff, 0);
            send_item(k[2:0], 1'b0, 1'b1, 1'b1, 32'hfffffff9, 32'd0, 0);
        end
        send_item(F3_ADD, 1'b1, 1'b0, 1'b1, 32'd5, 32'd7, 0);
        send_item(F3_ADD, 1'b1, 1'b1, 1'b0, 32'hffffffff, 32'd1, 0);
        send_item(F3_SRL, 1'b1, 1'b0, 1'b0, 32'h80000000, 32'd31, 0);
        send_item(F3_SRL, 1'b1, 1'b0, 1'b1, 32'h80000000, 32'hffffffe0, 0);
        send_item(F3_SLL, 1'b1, 1'b1, 1'b0, 32'hffffffff, 32'd31, 0);
        send_item(F3_SLT, 1'b0, 1'b0, 1'b1, 32'h80000000, 32'h7fffffff, 0);
        send_item(F3_SLTU, 1'b0, 1'b0, 1'b0, 32'h80000000, 32'h7fffffff, 0);
        send_item(F3_REM, 1'b0, 1'b1, 1'b1, 32'hfffffff9, 32'd2, 1);
        for (k = 0; k < N_RANDOM; k++)
            send_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      pick_operand(), pick_operand(), pick_gap());
        start <= 1'b0;
        wait_cycles = 0;
        while (sb.pending_results.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_top: errors");
        $finish;
    end
endmodule
`default_nettype wire
